// ===== src/hdep_pkg.sv =====
// Shared types, constants and helper functions for the HTTP date parser.
package hdep_pkg;

    localparam int unsigned NumW     = 16;
    localparam int unsigned EpochW   = 43;
    localparam int unsigned DaysW    = 27;
    localparam logic [NumW-1:0] NumMax = 16'hFFFF;

    // Value selected for the digit accumulator
    typedef enum logic [2:0] {
        FEED_NONE,
        FEED_DAY,
        FEED_YEAR,
        FEED_HOUR,
        FEED_MIN,
        FEED_SEC
    } t_feed;

    // Commands from controller to datapath
    typedef struct packed {
        logic  open_pre;    // reopen the number before feeding
        logic  open_post;   // reopen the number after feeding
        t_feed feed;
        logic  month_byte;
        logic  suffix;      // asctime form selected
        logic  calc1;
        logic  calc2;
        logic  calc3;
        logic  calc4;
        logic  load;
        logic  clr;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_full;
    } t_sts;

    localparam logic [23:0] MonthNames [12] = '{
        24'h6A616E, 24'h666562, 24'h6D6172, 24'h617072,
        24'h6D6179, 24'h6A756E, 24'h6A756C, 24'h617567,
        24'h736570, 24'h6F6374, 24'h6E6F76, 24'h646563
    };

    function automatic logic is_sp(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // (153*m - 457) / 5 for the shifted month m = 3..14
    function automatic logic [8:0] month_days(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd3:    d = 9'd0;
            4'd4:    d = 9'd31;
            4'd5:    d = 9'd61;
            4'd6:    d = 9'd92;
            4'd7:    d = 9'd122;
            4'd8:    d = 9'd153;
            4'd9:    d = 9'd184;
            4'd10:   d = 9'd214;
            4'd11:   d = 9'd245;
            4'd12:   d = 9'd275;
            4'd13:   d = 9'd306;
            4'd14:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== src/hdep_ctrl.sv =====
// Controller: parse phase state machine and epoch calculation sequencer.
module hdep_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_char_byte,
    input  logic              i_is_last,
    input  logic              i_stall,
    input  hdep_pkg::t_sts    i_sts,
    output logic              o_stall,
    output hdep_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        PH_LEAD_SP, PH_WEEK, PH_PRE_SP, PH_DAY, PH_MONTH, PH_THIRD, PH_THIRD_SP,
        PH_HOUR, PH_MINUTE, PH_SECOND, PH_TAIL_SP, PH_YEAR
    } t_phase;

    typedef enum logic [2:0] {
        ST_PARSE, ST_C1, ST_C2, ST_C3, ST_C4, ST_OUT
    } t_state;

    t_phase r_phase, n_phase, eff;
    t_state r_state, n_state;
    logic   r_suffix, n_suffix;
    logic   sp, dig, dash, comma, colon, take, open_pre;
    hdep_pkg::t_cmd cmd;

    assign sp    = hdep_pkg::is_sp(i_char_byte);
    assign dig   = hdep_pkg::is_dig(i_char_byte);
    assign dash  = (i_char_byte == 8'h2D);
    assign comma = (i_char_byte == 8'h2C);
    assign colon = (i_char_byte == 8'h3A);
    assign take  = i_valid && (r_state == ST_PARSE);

    // Byte decode: skip phases fall through to their successor on a non-space byte
    always_comb begin
        eff      = r_phase;
        open_pre = 1'b0;
        n_suffix = r_suffix;
        if (!sp) begin
            unique case (r_phase)
                PH_LEAD_SP: eff = PH_WEEK;
                PH_PRE_SP: begin
                    if (dig) begin
                        eff      = PH_DAY;
                        open_pre = 1'b1;
                        n_suffix = 1'b0;
                    end else begin
                        eff = PH_MONTH;
                    end
                end
                PH_THIRD_SP: begin
                    eff      = PH_HOUR;
                    open_pre = 1'b1;
                end
                PH_TAIL_SP: begin
                    eff      = PH_YEAR;
                    open_pre = 1'b1;
                end
                default: eff = r_phase;
            endcase
        end

        cmd            = '0;
        cmd.suffix     = r_suffix;
        cmd.open_pre   = open_pre;
        n_phase        = eff;
        unique case (eff)
            PH_WEEK:   if (comma || sp) n_phase = PH_PRE_SP;
            PH_DAY: begin
                cmd.feed = hdep_pkg::FEED_DAY;
                if (dash || sp) n_phase = PH_MONTH;
            end
            PH_MONTH: begin
                cmd.month_byte = 1'b1;
                if (dash || sp) begin
                    cmd.open_post = 1'b1;
                    n_phase       = PH_THIRD;
                end
            end
            PH_THIRD: begin
                cmd.feed = r_suffix ? hdep_pkg::FEED_DAY : hdep_pkg::FEED_YEAR;
                if (sp) n_phase = PH_THIRD_SP;
            end
            PH_HOUR: begin
                cmd.feed = hdep_pkg::FEED_HOUR;
                if (colon) begin
                    cmd.open_post = 1'b1;
                    n_phase       = PH_MINUTE;
                end
            end
            PH_MINUTE: begin
                cmd.feed = hdep_pkg::FEED_MIN;
                if (colon) begin
                    cmd.open_post = 1'b1;
                    n_phase       = PH_SECOND;
                end
            end
            PH_SECOND: begin
                cmd.feed = hdep_pkg::FEED_SEC;
                if (r_suffix && sp) n_phase = PH_TAIL_SP;
            end
            PH_YEAR:   cmd.feed = hdep_pkg::FEED_YEAR;
            default:   n_phase = eff;
        endcase

        // Only drive byte commands on an accepted byte
        if (!take) begin
            cmd.feed       = hdep_pkg::FEED_NONE;
            cmd.month_byte = 1'b0;
            cmd.open_pre   = 1'b0;
            cmd.open_post  = 1'b0;
            n_phase        = r_phase;
            n_suffix       = r_suffix;
        end

        // Calculation sequence
        n_state = r_state;
        unique case (r_state)
            ST_PARSE: if (take && i_is_last) n_state = ST_C1;
            ST_C1: begin
                cmd.calc1 = 1'b1;
                n_state   = ST_C2;
            end
            ST_C2: begin
                cmd.calc2 = 1'b1;
                n_state   = ST_C3;
            end
            ST_C3: begin
                cmd.calc3 = 1'b1;
                n_state   = ST_C4;
            end
            ST_C4: begin
                cmd.calc4 = 1'b1;
                cmd.clr   = 1'b1;
                n_phase   = PH_LEAD_SP;
                n_suffix  = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (!i_sts.out_full || !i_stall) begin
                    cmd.load = 1'b1;
                    n_state  = ST_PARSE;
                end
            end
            default: n_state = ST_PARSE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_PARSE;
            r_phase  <= PH_LEAD_SP;
            r_suffix <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_suffix <= n_suffix;
        end
    end

    assign o_stall = (r_state != ST_PARSE);
    assign o_cmd   = cmd;

endmodule

// ===== src/hdep_dp.sv =====
// Datapath: number accumulators, month window and epoch arithmetic.
module hdep_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [7:0]                  i_char_byte,
    input  logic                        i_stall,
    input  hdep_pkg::t_cmd              i_cmd,
    output hdep_pkg::t_sts              o_sts,
    output logic                        o_valid,
    output logic signed [hdep_pkg::EpochW-1:0] o_epoch_seconds,
    output logic                        o_status
);

    localparam int unsigned W = hdep_pkg::NumW;

    logic [W-1:0]  r_day, r_year, r_hour, r_min, r_sec;
    logic [W-1:0]  n_day, n_year, n_hour, n_min, n_sec;
    logic [3:0]    r_month, n_month;
    logic [23:0]   r_win, n_win;
    logic [1:0]    r_wcnt, n_wcnt;
    logic          r_open, n_open, open_eff;
    logic [W-1:0]  cur, fed;
    logic [W+3:0]  acc;
    logic          delim;

    // Calculation registers
    logic [W-1:0]  r_y;
    logic [3:0]    r_m;
    logic          r_bad;
    logic [9:0]    r_q100;
    logic [24:0]   r_y365;
    logic [8:0]    r_mtab;
    logic signed [hdep_pkg::DaysW-1:0] r_days;
    logic signed [hdep_pkg::EpochW:0]  r_pd;
    logic [27:0]   r_ph;
    logic [21:0]   r_pm;
    logic [W-1:0]  r_ps;
    logic          r_bad2;
    logic          r_out_valid;
    logic signed [hdep_pkg::EpochW-1:0] r_out_epoch;
    logic          r_out_status;

    logic [W-1:0]  y_base;
    logic [28:0]   q_prod;
    logic signed [hdep_pkg::EpochW:0] sum;
    logic [3:0]    match;

    // Digit accumulation for the selected field
    always_comb begin
        unique case (i_cmd.feed)
            hdep_pkg::FEED_DAY:  cur = r_day;
            hdep_pkg::FEED_YEAR: cur = r_year;
            hdep_pkg::FEED_HOUR: cur = r_hour;
            hdep_pkg::FEED_MIN:  cur = r_min;
            hdep_pkg::FEED_SEC:  cur = r_sec;
            default:             cur = '0;
        endcase
        acc      = {4'd0, cur} * 20'd10 + {16'd0, i_char_byte[3:0]};
        fed      = (acc > {4'd0, hdep_pkg::NumMax}) ? hdep_pkg::NumMax : acc[W-1:0];
        open_eff = r_open | i_cmd.open_pre;
        n_open   = open_eff;
        n_day    = r_day;
        n_year   = r_year;
        n_hour   = r_hour;
        n_min    = r_min;
        n_sec    = r_sec;
        if (i_cmd.feed != hdep_pkg::FEED_NONE && open_eff) begin
            if (hdep_pkg::is_dig(i_char_byte)) begin
                unique case (i_cmd.feed)
                    hdep_pkg::FEED_DAY:  n_day  = fed;
                    hdep_pkg::FEED_YEAR: n_year = fed;
                    hdep_pkg::FEED_HOUR: n_hour = fed;
                    hdep_pkg::FEED_MIN:  n_min  = fed;
                    hdep_pkg::FEED_SEC:  n_sec  = fed;
                    default:             n_day  = r_day;
                endcase
            end else begin
                n_open = 1'b0;
            end
        end
        if (i_cmd.open_post) n_open = 1'b1;
    end

    // Month window: three folded letters, matched on the following byte
    always_comb begin
        delim = (i_char_byte == 8'h2D) || hdep_pkg::is_sp(i_char_byte);
        match = '0;
        for (int i = 0; i < 12; i++) begin
            if (r_win == hdep_pkg::MonthNames[i]) match = 4'(i + 1);
        end
        n_win   = r_win;
        n_wcnt  = r_wcnt;
        n_month = r_month;
        if (i_cmd.month_byte) begin
            if (r_wcnt == 2'd3) begin
                n_month = match;
            end else if (!delim) begin
                n_win  = {r_win[15:0], hdep_pkg::fold(i_char_byte)};
                n_wcnt = r_wcnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_open  <= 1'b1;
            r_day   <= '0;
            r_year  <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_month <= '0;
            r_win   <= '0;
            r_wcnt  <= '0;
        end else begin
            r_open  <= n_open;
            r_day   <= n_day;
            r_year  <= n_year;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_month <= n_month;
            r_win   <= n_win;
            r_wcnt  <= n_wcnt;
        end
    end

    // Epoch arithmetic, one stage per command
    assign y_base = (r_year < 16'd100)
                  ? r_year + (i_cmd.suffix ? 16'd1900 : 16'd2000) : r_year;
    // y/100 as (y/4)/25, reciprocal exact over the full 16-bit range
    assign q_prod = {15'd0, r_y[15:2]} * 29'd20972;
    assign sum    = r_pd + $signed({16'd0, r_ph}) + $signed({22'd0, r_pm})
                  + $signed({28'd0, r_ps});

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc1) begin
            r_bad <= (r_month == 4'd0);
            if (r_month < 4'd3) begin
                r_y <= y_base - 16'd1;
                r_m <= r_month + 4'd12;
            end else begin
                r_y <= y_base;
                r_m <= r_month;
            end
        end
        if (i_cmd.calc2) begin
            r_q100 <= q_prod[28:19];
            r_y365 <= {9'd0, r_y} * 25'd365;
            r_mtab <= hdep_pkg::month_days(r_m);
        end
        if (i_cmd.calc3) begin
            r_days <= $signed({11'd0, r_day}) + $signed({18'd0, r_mtab})
                    + $signed({2'd0, r_y365}) + $signed({13'd0, r_y[15:2]})
                    - $signed({17'd0, r_q100}) + $signed({19'd0, r_q100[9:2]})
                    - 27'sd719469;
        end
        if (i_cmd.calc4) begin
            r_pd   <= 44'(r_days * 44'sd86400);
            r_ph   <= {12'd0, r_hour} * 28'd3600;
            r_pm   <= {6'd0, r_min} * 22'd60;
            r_ps   <= r_sec;
            r_bad2 <= r_bad;
        end
        if (i_cmd.load) begin
            r_out_epoch  <= r_bad2 ? '0 : sum[hdep_pkg::EpochW-1:0];
            r_out_status <= r_bad2;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_full  = r_out_valid;
    assign o_valid         = r_out_valid;
    assign o_epoch_seconds = r_out_epoch;
    assign o_status        = r_out_status;

endmodule

// ===== src/http_date_to_epoch_parser_top.sv =====
// Top level of the HTTP date to epoch seconds parser.
// Usage:
//   Input channel: one character word per accepted cycle (i_char_byte, i_is_last).
//   A word is accepted when i_valid is high and o_stall is low.
//   Output channel: one word per string (o_epoch_seconds, o_status), taken when
//   o_valid is high and i_stall is low.
// Throughput: one character per cycle while parsing. The word marked last starts
//   a five-stage epoch calculation (year/month adjust, divide-by-100 and 365*y
//   multipliers, day sum, 86400/3600/60 multipliers, final add); the input is
//   stalled while the calculation runs.
// Receiver stall: the result stays in the output register; a following result
//   waits in the final stage, holding o_stall high, until the register is free.
// Reset: synchronous active-low i_rst_n returns the parser to skipping leading
//   white space and drops any pending result.
module http_date_to_epoch_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [hdep_pkg::EpochW-1:0] o_epoch_seconds,
    output logic        o_status
);

    hdep_pkg::t_cmd cmd;
    hdep_pkg::t_sts sts;

    hdep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_byte (i_char_byte),
        .i_is_last   (i_is_last),
        .i_stall     (i_stall),
        .i_sts       (sts),
        .o_stall     (o_stall),
        .o_cmd       (cmd)
    );

    hdep_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_char_byte     (i_char_byte),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_epoch_seconds (o_epoch_seconds),
        .o_status        (o_status)
    );

    // The last character always starts the calculation
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_is_last |=> o_stall)
        else $error("parser not busy after last character");

    // An unknown month gives zero seconds
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_epoch_seconds == '0)
        else $error("nonzero seconds with unknown month");

    // No result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

// ===== verif/tb.sv =====
// Testbench for the HTTP date to epoch seconds parser: streamed strings checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchLimit = 5000;

    // Parse phases of the predictor
    typedef enum int {
        P_LEAD_SP, P_WEEK, P_PRE_SP, P_DAY, P_MONTH, P_THIRD, P_THIRD_SP,
        P_HOUR, P_MINUTE, P_SECOND, P_TAIL_SP, P_YEAR
    } t_phase;

    typedef struct {
        logic signed [hdep_pkg::EpochW-1:0] secs;
        logic                     status;
    } t_date_result;

    // Scoreboard: tracks parser state and the queue of pending dates
    class date_scoreboard;
        t_phase      phase;
        bit          asc_form;
        bit [23:0]   mwin;
        int unsigned mcnt;
        bit          open;
        int unsigned day, mon, yr, hr, mn, sc;
        t_date_result pending[$];
        int          errors;
        int          n_checked;

        function void clear_state();
            phase = P_LEAD_SP; asc_form = 1; mwin = 0; mcnt = 0; open = 1;
            day = 0; mon = 0; yr = 0; hr = 0; mn = 0; sc = 0;
        endfunction

        function bit sp(bit [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function bit dig(bit [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function int unsigned acc(int unsigned v, bit [7:0] c);
            int unsigned n;
            if (!open) return v;
            if (dig(c)) begin
                n = v * 10 + (c - 8'h30);
                return n > 65535 ? 65535 : n;
            end
            open = 0;
            return v;
        endfunction

        function void advance(bit [7:0] c);
            bit [7:0] lc;
            bit again;
            again = 1;
            while (again) begin
                again = 0;
                case (phase)
                    P_LEAD_SP: if (!sp(c)) begin phase = P_WEEK; again = 1; end
                    P_WEEK: if (c == 8'h2C || sp(c)) phase = P_PRE_SP;
                    P_PRE_SP: if (!sp(c)) begin
                        if (dig(c)) begin
                            asc_form = 0; open = 1; phase = P_DAY;
                        end else begin
                            phase = P_MONTH;
                        end
                        again = 1;
                    end
                    P_DAY: begin
                        day = acc(day, c);
                        if (c == 8'h2D || sp(c)) phase = P_MONTH;
                    end
                    P_MONTH: begin
                        if (mcnt == 3) begin
                            mon = 0;
                            for (int i = 0; i < 12; i++)
                                if (mwin == hdep_pkg::MonthNames[i]) mon = i + 1;
                        end else if (c != 8'h2D && !sp(c)) begin
                            lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
                            mwin = {mwin[15:0], lc};
                            mcnt++;
                        end
                        if (c == 8'h2D || sp(c)) begin open = 1; phase = P_THIRD; end
                    end
                    P_THIRD: begin
                        if (asc_form) day = acc(day, c);
                        else yr = acc(yr, c);
                        if (sp(c)) phase = P_THIRD_SP;
                    end
                    P_THIRD_SP: if (!sp(c)) begin open = 1; phase = P_HOUR; again = 1; end
                    P_HOUR: begin
                        hr = acc(hr, c);
                        if (c == 8'h3A) begin open = 1; phase = P_MINUTE; end
                    end
                    P_MINUTE: begin
                        mn = acc(mn, c);
                        if (c == 8'h3A) begin open = 1; phase = P_SECOND; end
                    end
                    P_SECOND: begin
                        sc = acc(sc, c);
                        if (asc_form && sp(c)) phase = P_TAIL_SP;
                    end
                    P_TAIL_SP: if (!sp(c)) begin open = 1; phase = P_YEAR; again = 1; end
                    P_YEAR: yr = acc(yr, c);
                    default: ;
                endcase
            end
        endfunction

        // Note an accepted character word; queue a date on the last one
        function void note_char(bit [7:0] c, bit last);
            longint y, m, days, t;
            t_date_result r;
            advance(c);
            if (!last) return;
            y = yr;
            if (y < 100) y += asc_form ? 1900 : 2000;
            m = mon;
            t = 0;
            r.status = 0;
            if (m < 1 || m > 12) begin
                r.status = 1;
            end else begin
                if (m < 3) begin m += 12; y -= 1; end
                days = day + (153 * m - 457) / 5 + 365 * y + y / 4 - y / 100 + y / 400
                       - 719469;
                t = 86400 * days + 3600 * longint'(hr) + 60 * longint'(mn) + sc;
            end
            r.secs = t[hdep_pkg::EpochW-1:0];
            pending.push_back(r);
            clear_state();
        endfunction

        // Check a result word against the oldest queued date
        function void check_result(logic signed [hdep_pkg::EpochW-1:0] secs, logic status);
            t_date_result e;
            n_checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %0d status %0d", secs, status);
                return;
            end
            e = pending.pop_front();
            if (secs !== e.secs || status !== e.status) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: expected %0d/%0d, got %0d/%0d",
                             n_checked, e.secs, e.status, secs, status);
            end
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_valid = 0;
    logic              o_stall;
    logic [7:0]        i_char_byte = 0;
    logic              i_is_last = 0;
    logic              o_valid;
    logic              i_stall = 1;
    logic signed [hdep_pkg::EpochW-1:0] o_epoch_seconds;
    logic              o_status;

    date_scoreboard sb = new();
    int  idle_cycles = 0;
    int  n_chars = 0;
    bit  done_driving;

    http_date_to_epoch_parser_top dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // Mostly short gaps, now and then a long one
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (i_valid && !o_stall) begin
                sb.note_char(i_char_byte, i_is_last);
                n_chars <= n_chars + 1;
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_epoch_seconds, o_status);
            end
            if (idle_cycles > WatchLimit) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver stall pattern
    initial begin
        int g;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            i_stall <= 0;
            repeat (1 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 20)))
                @(negedge i_clk);
            g = gap_len();
            if (g > 0) begin
                i_stall <= 1;
                repeat (g) @(negedge i_clk);
            end
        end
    end

    // Send one character word and wait for its acceptance
    task automatic send_char(bit [7:0] c, bit last);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1;
        i_char_byte <= c;
        i_is_last <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    function string num_str(int unsigned v, int w);
        string s;
        s = $sformatf("%0d", v);
        while (s.len() < w) s = {"0", s};
        return s;
    endfunction

    function string rand_sp();
        bit [7:0] c;
        c = $urandom_range(0, 6) == 0 ? 8'h20 : 8'h20;
        if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(8'h09, 8'h0D));
        return string'(c);
    endfunction

    // Random date in one of three forms, with random month case and values, sometimes an unknown month
    function string rand_date();
        string mons[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                            "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
        string days[7] = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
        string mo, s;
        int kind;
        int unsigned yv;
        mo = mons[$urandom_range(0, 11)];
        if ($urandom_range(0, 2) == 0) mo = mo.toupper();
        if ($urandom_range(0, 12) == 0) mo = "Xyz";
        yv = $urandom_range(0, 3) == 0 ? $urandom_range(0, 99) : $urandom_range(1970, 2400);
        if ($urandom_range(0, 30) == 0) yv = $urandom_range(0, 99999);
        kind = $urandom_range(0, 2);
        case (kind)
            0: s = {days[$urandom_range(0, 6)], ",", rand_sp(),
                    num_str($urandom_range(1, 31), 2), rand_sp(), mo, rand_sp(),
                    num_str(yv, 4), rand_sp(), num_str($urandom_range(0, 23), 2), ":",
                    num_str($urandom_range(0, 59), 2), ":",
                    num_str($urandom_range(0, 60), 2), " GMT"};
            1: s = {days[$urandom_range(0, 6)], "day, ",
                    num_str($urandom_range(1, 31), 2), "-", mo, "-",
                    num_str(yv % 100, 2), " ", num_str($urandom_range(0, 23), 2), ":",
                    num_str($urandom_range(0, 59), 2), ":",
                    num_str($urandom_range(0, 59), 2), " GMT"};
            default: s = {days[$urandom_range(0, 6)], " ", mo, rand_sp(),
                          num_str($urandom_range(1, 31), $urandom_range(1, 2)), rand_sp(),
                          num_str($urandom_range(0, 23), 2), ":",
                          num_str($urandom_range(0, 59), 2), ":",
                          num_str($urandom_range(0, 59), 2), rand_sp(), num_str(yv, 1)};
        endcase
        // Sometimes truncate, to exercise short strings
        if ($urandom_range(0, 9) == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
        return s;
    endfunction

    // Stimulus
    initial begin
        string s;
        sb.clear_state();
        sb.errors = 0;
        sb.n_checked = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: each form, extremes, saturation, unknown month, short strings
        send_string("Sun, 06 Nov 1994 08:49:37 GMT");
        send_string("Sunday, 06-Nov-94 08:49:37 GMT");
        send_string("Sun Nov  6 08:49:37 1994");
        send_string("  \tMon, 01 jAN 1970 00:00:00 GMT");
        send_string("Thu, 31 DEC 99999 99999:99999:99999");
        send_string("Fri Feb 29 23:59:59 00");
        send_string("Sat, 01 Foo 2000 00:00:00");
        send_string("Sat, 01 Ja");
        send_string("Sat, 01 Jan");
        send_string("X,");
        send_string("Z");
        send_string(" ");
        send_string("Tue, -5 Mar +7 -1:+2: 3");
        send_string("Wed Apr 1 1:2:3 1999 trailing junk");
        send_string("Mon,01-Jul-2038 03:14:07");
        // Every byte value in one long string, then short noise strings
        for (int b = 0; b < 256; b++) send_char(b[7:0], 0);
        send_char(8'hFF, 1);
        for (int b = 0; b < 256; b += 37) send_char(b[7:0], b % 2 == 0);
        send_char(8'h00, 1);

        // Random: mostly well-formed dates, some noise strings
        while (n_chars < 1750) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)), 0);
                send_char(8'($urandom_range(0, 255)), 1);
            end else begin
                s = rand_date();
                if (s.len() == 0) s = "M";
                send_string(s);
            end
        end
        i_valid <= 0;

        // Drain
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d characters, checked %0d dates across all three formats.",
                 n_chars, sb.n_checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
